// ===== design/kscl_pkg.sv =====
// Shared types, key codes and constants for the keypad scan code lock.
package kscl_pkg;

    localparam int ENTRY_DIGITS = 11;
    localparam int BCD_W        = 4 * ENTRY_DIGITS;
    localparam int EXT_W        = BCD_W + 4;
    localparam int VALUE_W      = 37;
    localparam int FULL_W       = 40;
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_AW       = $clog2(OUT_DEPTH);
    localparam int OUT_CW       = $clog2(OUT_DEPTH + 1);

    localparam logic [3:0] KEY_IDLE  = 4'd0;
    localparam logic [3:0] KEY_CLEAR = 4'd10;
    localparam logic [3:0] KEY_BACK  = 4'd11;
    localparam logic [3:0] KEY_OK    = 4'd12;
    localparam logic [3:0] KEY_NONE  = 4'd13;

    localparam logic [VALUE_W-1:0] SECRET_RESET = 37'd64340500065;

    typedef struct packed {
        logic [1:0]       row_drive;
        logic             key_event;
        logic [3:0]       key_code;
        logic [EXT_W-1:0] ext_bcd;
    } scan_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] entered_value;
        logic               led_on;
        logic [3:0]         key_code;
        logic               key_event;
        logic [1:0]         row_drive;
    } result_t;

    function automatic logic [3:0] decode_key(input logic [15:0] map);
        logic [3:0] key;
        case (map)
            16'h0001: key = 4'd7;
            16'h0002: key = 4'd4;
            16'h0004: key = 4'd1;
            16'h0008: key = 4'd0;
            16'h0010: key = 4'd8;
            16'h0020: key = 4'd5;
            16'h0040: key = 4'd2;
            16'h0100: key = 4'd9;
            16'h0200: key = 4'd6;
            16'h0400: key = 4'd3;
            16'h1000: key = KEY_CLEAR;
            16'h2000: key = KEY_BACK;
            16'h8000: key = KEY_OK;
            default:  key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

// ===== design/keypad_scan_code_lock.sv =====
// Keypad scan code lock: scans a 4x4 keypad and checks the decimal entry against a code.
// Throughput: one word per cycle while s_tready is high; a credit count over
// pipeline and result queue sets s_tready.
// Reset: row 0, empty key map, entry 0, LED off, code 64340500065, queue empty.
module keypad_scan_code_lock (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [36:0] cfg_wdata,     // secret_code
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [3:0] column_levels, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [1:0] row_drive, [5:2] key_code, [6] led_on,
                                       // [43:7] entered_value, [47:44] zero
    output logic        m_tuser        // key_event
);

    logic [kscl_pkg::VALUE_W-1:0] secret_reg;
    logic [kscl_pkg::OUT_CW-1:0]  credit_reg, credit_next;
    logic                         s_acc, m_acc;
    logic                         item_valid;
    kscl_pkg::scan_item_t         item;
    logic                         res_valid;
    kscl_pkg::result_t            res;
    kscl_pkg::result_t            head;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // count words in flight and queued so the queue never overflows
    always_comb begin
        credit_next = credit_reg + kscl_pkg::OUT_CW'(s_acc) - kscl_pkg::OUT_CW'(m_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg <= kscl_pkg::SECRET_RESET;
            credit_reg <= '0;
            s_tready   <= 1'b0;
        end else begin
            credit_reg <= credit_next;
            s_tready   <= (credit_next < kscl_pkg::OUT_CW'(kscl_pkg::OUT_DEPTH));
            if (cfg_we) begin
                secret_reg <= cfg_wdata;
            end
        end
    end

    kscl_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_acc),
        .column_levels (s_tdata[3:0]),
        .item_valid    (item_valid),
        .item          (item)
    );

    kscl_conv u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .secret_code (secret_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    kscl_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_en    (m_acc),
        .rd_valid (m_tvalid),
        .rd_data  (head)
    );

    assign m_tdata = {4'h0, head.entered_value, head.led_on, head.key_code, head.row_drive};
    assign m_tuser = head.key_event;

endmodule

// ===== design/kscl_scan.sv =====
// Row scan, pressed map, key decode and decimal entry held as BCD digits.
module kscl_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [3:0]           column_levels,
    output logic                 item_valid,
    output kscl_pkg::scan_item_t item
);

    logic [1:0]                    row_reg, row_next;
    logic [15:0]                   map_reg, map_next;
    logic [kscl_pkg::BCD_W-1:0]    bcd_reg, bcd_next;
    logic                          item_valid_reg;
    kscl_pkg::scan_item_t          item_reg;
    logic [3:0]                    pressed;
    logic [3:0]                    shift;
    logic                          press_edge;
    logic [3:0]                    key;
    logic [kscl_pkg::EXT_W-1:0]    ext;

    always_comb begin
        pressed    = ~column_levels;
        shift      = {row_reg, 2'b00};
        map_next   = (map_reg & ~(16'hF << shift)) | (16'(pressed) << shift);
        row_next   = row_reg + 2'd1;
        // the previous map equals the map before this word
        press_edge = (map_next != 16'd0) && (map_reg == 16'd0);
        key        = press_edge ? kscl_pkg::decode_key(map_next) : kscl_pkg::KEY_IDLE;
        ext        = {4'b0000, bcd_reg};
        if (press_edge) begin
            case (key)
                kscl_pkg::KEY_CLEAR: ext = '0;
                kscl_pkg::KEY_BACK:  ext = {8'h00, bcd_reg[kscl_pkg::BCD_W-1:4]};
                kscl_pkg::KEY_OK:    ext = {4'b0000, bcd_reg};
                kscl_pkg::KEY_NONE:  ext = {4'b0000, bcd_reg};
                default:             ext = {bcd_reg, key};
            endcase
        end
        // drop the digit beyond the entry length
        bcd_next = ext[kscl_pkg::BCD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= 2'd0;
            map_reg        <= 16'd0;
            bcd_reg        <= '0;
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= in_valid;
            if (in_valid) begin
                row_reg  <= row_next;
                map_reg  <= map_next;
                bcd_reg  <= bcd_next;
                item_reg <= '{row_drive: row_next, key_event: press_edge,
                              key_code: key, ext_bcd: ext};
            end
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/kscl_conv.sv =====
// BCD to binary conversion pipeline, code compare and LED update.
module kscl_conv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  kscl_pkg::scan_item_t          item,
    input  logic [kscl_pkg::VALUE_W-1:0]  secret_code,
    output logic                          res_valid,
    output kscl_pkg::result_t             res
);

    function automatic logic [13:0] group_bin(input logic [15:0] d);
        logic [13:0] acc;
        acc = 14'(d[15:12]) * 14'd1000 + 14'(d[11:8]) * 14'd100
            + 14'(d[7:4]) * 14'd10 + 14'(d[3:0]);
        return acc;
    endfunction

    // first stage: four-digit groups
    logic        st1_valid_reg;
    logic [1:0]  st1_row_reg;
    logic        st1_event_reg;
    logic [3:0]  st1_key_reg;
    logic [13:0] st1_g0_reg, st1_g1_reg, st1_g2_reg;
    logic [3:0]  st1_top_reg;

    // second stage: entry value in binary
    logic                         st2_valid_reg;
    logic [1:0]                   st2_row_reg;
    logic                         st2_event_reg;
    logic [3:0]                   st2_key_reg;
    logic [kscl_pkg::VALUE_W-1:0] st2_low_reg;
    logic [3:0]                   st2_top_reg;

    logic                         led_reg, led_next;
    logic [kscl_pkg::FULL_W-1:0]  full;
    logic                         match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            led_reg       <= 1'b0;
        end else begin
            st1_valid_reg <= item_valid;
            st2_valid_reg <= st1_valid_reg;
            if (st2_valid_reg) begin
                led_reg <= led_next;
            end
            if (item_valid) begin
                st1_row_reg   <= item.row_drive;
                st1_event_reg <= item.key_event;
                st1_key_reg   <= item.key_code;
                st1_g0_reg    <= group_bin(item.ext_bcd[15:0]);
                st1_g1_reg    <= group_bin(item.ext_bcd[31:16]);
                st1_g2_reg    <= group_bin({4'h0, item.ext_bcd[43:32]});
                st1_top_reg   <= item.ext_bcd[47:44];
            end
            if (st1_valid_reg) begin
                st2_row_reg   <= st1_row_reg;
                st2_event_reg <= st1_event_reg;
                st2_key_reg   <= st1_key_reg;
                st2_low_reg   <= 37'(st1_g2_reg) * 37'd100000000
                               + 37'(st1_g1_reg) * 37'd10000 + 37'(st1_g0_reg);
                st2_top_reg   <= st1_top_reg;
            end
        end
    end

    always_comb begin
        // the compare sees the entry before the top digit is dropped
        full  = 40'(st2_low_reg) + 40'(st2_top_reg) * 40'd100000000000;
        match = (full == 40'(secret_code));
        led_next = led_reg;
        if (st2_event_reg) begin
            if (!match) begin
                led_next = 1'b0;
            end else if (st2_key_reg == kscl_pkg::KEY_OK) begin
                led_next = 1'b1;
            end
        end
    end

    assign res_valid = st2_valid_reg;
    assign res = '{entered_value: st2_low_reg, led_on: led_next, key_code: st2_key_reg,
                   key_event: st2_event_reg, row_drive: st2_row_reg};

endmodule

// ===== design/kscl_fifo.sv =====
// Result queue between the conversion pipeline and the output channel.
module kscl_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  kscl_pkg::result_t wr_data,
    input  logic              rd_en,
    output logic              rd_valid,
    output kscl_pkg::result_t rd_data
);

    kscl_pkg::result_t             mem [kscl_pkg::OUT_DEPTH];
    logic [kscl_pkg::OUT_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [kscl_pkg::OUT_CW-1:0]   count_reg, count_next;

    always_comb begin
        count_next = count_reg + kscl_pkg::OUT_CW'(wr_en) - kscl_pkg::OUT_CW'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

endmodule

// ===== tb/tb_keypad_scan_code_lock.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the keypad scan code lock: scanned key strokes against a lock model.

typedef struct {
    logic [1:0]                   row;
    logic                         edge_seen;
    logic [3:0]                   key;
    logic                         led;
    logic [kscl_pkg::VALUE_W-1:0] value;
} lock_word_t;

class lock_scoreboard;
    logic [kscl_pkg::VALUE_W-1:0] code;
    logic [1:0]                   row;
    logic [15:0]                  key_map;
    logic [15:0]                  last_map;
    logic [63:0]                  entry;
    logic                         led;
    logic [3:0]                   key_at [16];
    lock_word_t                   awaited [$];
    int                           errors;

    function new();
        code     = kscl_pkg::SECRET_RESET;
        row      = '0;
        key_map  = '0;
        last_map = '0;
        entry    = '0;
        led      = 1'b0;
        errors   = 0;
        key_at   = '{4'd7, 4'd4, 4'd1, 4'd0, 4'd8, 4'd5, 4'd2, kscl_pkg::KEY_NONE,
                     4'd9, 4'd6, 4'd3, kscl_pkg::KEY_NONE, kscl_pkg::KEY_CLEAR,
                     kscl_pkg::KEY_BACK, kscl_pkg::KEY_NONE, kscl_pkg::KEY_OK};
    endfunction

    // Work out the lock state after one scan tick and queue the word it must produce.
    function void note_column_word(logic [3:0] cols);
        lock_word_t  w;
        logic [63:0] v;
        int          b;
        key_map[{row, 2'b00} +: 4] = ~cols;
        row         = row + 2'd1;
        w.row       = row;
        w.edge_seen = 1'b0;
        w.key       = kscl_pkg::KEY_IDLE;
        if (key_map != '0 && last_map == '0) begin
            w.edge_seen = 1'b1;
            w.key       = kscl_pkg::KEY_NONE;
            if ($countones(key_map) == 1) begin
                for (b = 0; b < 16; b++)
                    if (key_map[b])
                        w.key = key_at[b];
            end
            v = entry;
            if (w.key == kscl_pkg::KEY_CLEAR)
                v = '0;
            else if (w.key == kscl_pkg::KEY_BACK)
                v = v / 10;
            else if (w.key < kscl_pkg::KEY_CLEAR)
                v = v * 10 + w.key;
            // compare before the wrap, as the design compares the entry before its top digit is dropped
            if (v != 64'(code))
                led = 1'b0;
            else if (w.key == kscl_pkg::KEY_OK)
                led = 1'b1;
            entry = v % 64'd100000000000;
        end
        last_map = key_map;
        w.led    = led;
        w.value  = entry[kscl_pkg::VALUE_W-1:0];
        awaited.push_back(w);
    endfunction

    function void check_result_word(logic [47:0] d, logic u);
        lock_word_t w;
        if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word %h at %0t", d, $realtime);
            return;
        end
        w = awaited.pop_front();
        if (d[1:0] !== w.row || u !== w.edge_seen || d[5:2] !== w.key
                || d[6] !== w.led || d[43:7] !== w.value) begin
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t (exp/act): row %0d/%0d press %0d/%0d key %0d/%0d",
                         $realtime, w.row, d[1:0], w.edge_seen, u, w.key, d[5:2],
                         " led %0d/%0d value %0d/%0d", w.led, d[6], w.value, d[43:7]);
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_keypad_scan_code_lock;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_WORDS = 160;
    localparam int BIT_CLEAR   = 12;
    localparam int BIT_BACK    = 13;
    localparam int BIT_OK      = 15;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [kscl_pkg::VALUE_W-1:0] cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic [7:0]                   s_tdata   = '0;
    logic                         m_tready  = 1'b0;
    logic                         s_tready;
    logic                         m_tvalid;
    logic [47:0]                  m_tdata;
    logic                         m_tuser;

    lock_scoreboard               sb;
    logic [1:0]                   tx_row     = '0;
    int                           burst_left = 0;
    int                           sent       = 0;
    int                           quiet      = 0;
    bit                           steady     = 1'b0;
    bit                           hold_req   = 1'b0;
    int                           digit_bit [10] = '{3, 2, 6, 10, 1, 5, 9, 0, 4, 8};
    int                           key_bit   [13] = '{3, 2, 6, 10, 1, 5, 9, 0, 4, 8, 12, 13, 15};
    int                           spare_bit [3]  = '{7, 11, 14};
    logic [kscl_pkg::VALUE_W-1:0] phase_code [8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    keypad_scan_code_lock u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_column_word(s_tdata[3:0]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result_word(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: stall in modes of random length; hold off entirely on request.
    initial begin
        int mode;
        int left;
        int n;
        mode = 0;
        left = 0;
        n    = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (80) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                n++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (n % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [3:0] cols);
        int gap;
        if (burst_left == 0) begin
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, cols};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tx_row = tx_row + 2'd1;
        sent++;
    endtask

    // Hold the keys of map for hold ticks, then release for rel ticks, driving the columns of whichever row is scanned.
    task automatic press_keys(input logic [15:0] map, input int hold, input int rel);
        repeat (hold) send_word(~map[{tx_row, 2'b00} +: 4]);
        repeat (rel) send_word(4'hF);
    endtask

    task automatic tap(input int b);
        press_keys(16'h1 << b, $urandom_range(4, 7), $urandom_range(4, 6));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_code(input logic [kscl_pkg::VALUE_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.code    = v;
        @(posedge aclk);
    endtask

    // Clear, type the current code digit by digit with the odd slip fixed by backspace, then OK.
    task automatic enter_code();
        longint unsigned c;
        int              dg [14];
        int              n;
        c = sb.code;
        n = 0;
        do begin
            dg[n] = int'(c % 10);
            c     = c / 10;
            n++;
        end while (c != 0);
        tap(BIT_CLEAR);
        for (int i = n - 1; i >= 0; i--) begin
            if ($urandom_range(0, 9) == 0) begin
                tap(digit_bit[$urandom_range(0, 9)]);
                tap(BIT_BACK);
            end
            tap(digit_bit[dg[i]]);
        end
        tap(BIT_OK);
    endtask

    // Directed opening: whole row pressed, then single keys on consecutive rows from row 1.
    task automatic directed_words();
        logic [3:0] cols_pressed [7];
        // unmapped, nine, backspace, seven, five, three, OK
        cols_pressed = '{4'b1000, 4'b0001, 4'b0010, 4'b0001, 4'b0010, 4'b0100, 4'b1000};
        send_word(4'h0);
        repeat (4) send_word(4'hF);
        foreach (cols_pressed[i]) begin
            send_word(~cols_pressed[i]);
            repeat (4) send_word(4'hF);
        end
    endtask

    task automatic random_step();
        int          pick;
        logic [15:0] map;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            enter_code();
        end else if (pick < 60) begin
            tap(key_bit[$urandom_range(0, 12)]);
        end else if (pick < 70) begin
            if ($urandom_range(0, 1) == 0)
                map = 16'h1 << spare_bit[$urandom_range(0, 2)];
            else
                map = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
            press_keys(map, $urandom_range(4, 7), $urandom_range(4, 6));
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 8)) send_word(4'($urandom_range(0, 15)));
            repeat (4) send_word(4'hF);
        end else if (pick < 86) begin
            // run past eleven digits so the entry wraps
            repeat ($urandom_range(12, 15)) tap(digit_bit[$urandom_range(0, 9)]);
        end else if (pick < 94) begin
            press_keys(16'h1 << key_bit[$urandom_range(0, 12)], $urandom_range(1, 3),
                       $urandom_range(1, 5));
        end else begin
            repeat ($urandom_range(2, 5)) tap(BIT_BACK);
        end
    endtask

    initial begin
        int target;
        sb = new();
        phase_code[0] = kscl_pkg::SECRET_RESET;
        phase_code[1] = '0;
        phase_code[2] = '1;
        phase_code[3] = 37'd99999999999;
        phase_code[4] = 37'd123456789012;
        phase_code[5] = kscl_pkg::VALUE_W'({$urandom, $urandom} % 64'd100000000000);
        phase_code[6] = kscl_pkg::VALUE_W'($urandom_range(0, 99999));
        phase_code[7] = kscl_pkg::VALUE_W'({$urandom, $urandom});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        directed_words();
        for (int p = 0; p < 8; p++) begin
            if (p > 0)
                write_code(phase_code[p]);
            steady = (p == 2);
            target = sent + PHASE_WORDS;
            enter_code();
            if (p == 3) begin
                // fill the block while the result side holds off
                steady   = 1'b1;
                hold_req = 1'b1;
                repeat (8) tap(key_bit[$urandom_range(0, 12)]);
                steady   = 1'b0;
            end
            if (p == 4) begin
                repeat (3) random_step();
                drain();
            end
            while (sent < target) random_step();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== keypad_scan_code_lock.f =====
design/kscl_pkg.sv
design/kscl_scan.sv
design/kscl_conv.sv
design/kscl_fifo.sv
design/keypad_scan_code_lock.sv
tb/tb_keypad_scan_code_lock.sv
